FILE: hdl/utf8_string_validator_macros.svh
// Assertion macros for the UTF-8 string validator.
`ifndef UTF8_STRING_VALIDATOR_MACROS_SVH
`define UTF8_STRING_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS
`define UTF8V_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8v assertion failed");
`define UTF8V_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8v assertion failed");
`else
`define UTF8V_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UTF8V_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/utf8v_pkg.sv
package utf8v_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D7FF;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00E000;
  localparam logic [CP_W-1:0] CP_BMP_TOP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_SUPP     = 21'h010000;
  localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN2     = 21'h000080;
  localparam logic [CP_W-1:0] CP_TAB      = 21'h000009;
  localparam logic [CP_W-1:0] CP_LF       = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR       = 21'h00000D;
  localparam logic [CP_W-1:0] CP_SPACE    = 21'h000020;

  localparam logic MODE_UNICODE = 1'b0;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } utf8v_cls_t;

  typedef struct packed {
    utf8v_cls_t  cls;
    logic [6:0]  data;
  } utf8v_tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utf8v_fifo_st_t;

  function automatic logic range_ok(input logic mode, input logic [CP_W-1:0] cp);
    logic ok;
    if (mode == MODE_UNICODE) begin
      ok = (cp <= CP_MAX);
    end else begin
      ok = (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
           ((cp >= CP_SPACE) && (cp <= CP_SURR_LO)) ||
           ((cp >= CP_SURR_HI) && (cp <= CP_BMP_TOP)) ||
           ((cp >= CP_SUPP) && (cp <= CP_MAX));
    end
    return ok;
  endfunction

endpackage

FILE: hdl/utf8v_in_if.sv
interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

FILE: hdl/utf8v_out_if.sv
interface utf8v_out_if;
  logic valid;
  logic ready;
  logic string_ok;

  modport source (output valid, output string_ok, input ready);
  modport sink (input valid, input string_ok, output ready);
endinterface

FILE: hdl/utf8v_fifo.sv
module utf8v_fifo
  import utf8v_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  utf8v_tok_t     push_tok,
  input  logic           pop,
  output utf8v_tok_t     head_tok,
  output utf8v_fifo_st_t st
);

  utf8v_tok_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign st.full  = (cnt_r == 2'd2);
  assign st.empty = (cnt_r == 2'd0);
  assign head_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/utf8v_front.sv
module utf8v_front
  import utf8v_pkg::*;
(
  utf8v_in_if.sink   in_ch,
  input  logic       fifo_full,
  output logic       push,
  output utf8v_tok_t push_tok
);

  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full;

  always_comb begin
    push_tok.data = in_ch.byte_in[6:0];
    case (in_ch.byte_in) inside
      8'h00:          push_tok.cls = CLS_ZERO;
      [8'h01:8'h7F]:  push_tok.cls = CLS_ASCII;
      [8'h80:8'hBF]:  push_tok.cls = CLS_CONT;
      [8'hC0:8'hDF]:  push_tok.cls = CLS_LEAD2;
      [8'hE0:8'hEF]:  push_tok.cls = CLS_LEAD3;
      [8'hF0:8'hF7]:  push_tok.cls = CLS_LEAD4;
      default:        push_tok.cls = CLS_BAD;
    endcase
  end

endmodule

FILE: hdl/utf8v_back.sv
module utf8v_back
  import utf8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        check_mode,
  input  logic        tok_valid,
  input  utf8v_tok_t  tok,
  output logic        pop,
  utf8v_out_if.source out_ch
);

  logic [CP_W-1:0] accum_r;
  logic [CP_W-1:0] accum_nxt;
  logic [1:0]      left_r;
  logic [1:0]      left_nxt;
  logic [1:0]      len_r;
  logic [1:0]      len_nxt;
  logic            err_r;
  logic            err_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_ok_r;
  logic            out_ok_nxt;
  logic [CP_W-1:0] cp_next;
  logic [CP_W-1:0] min_cp;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.string_ok = out_ok_r;

  assign pop = tok_valid &&
               ((tok.cls != CLS_ZERO) || !out_valid_r || out_ch.ready);

  assign cp_next = {accum_r[CP_W-7:0], tok.data[5:0]};

  always_comb begin
    case (len_r)
      2'd1:    min_cp = CP_MIN2;
      2'd2:    min_cp = CP_MIN3;
      default: min_cp = CP_SUPP;
    endcase
  end

  always_comb begin
    accum_nxt     = accum_r;
    left_nxt      = left_r;
    len_nxt       = len_r;
    err_nxt       = err_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop) begin
      if (tok.cls == CLS_ZERO) begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = !err_r && (left_r == 2'd0);
        accum_nxt     = '0;
        left_nxt      = 2'd0;
        len_nxt       = 2'd0;
        err_nxt       = 1'b0;
      end else if (!err_r) begin
        if (left_r == 2'd0) begin
          case (tok.cls)
            CLS_ASCII: begin
              err_nxt = !range_ok(check_mode, {{(CP_W-7){1'b0}}, tok.data});
            end
            CLS_LEAD2: begin
              accum_nxt = {{(CP_W-5){1'b0}}, tok.data[4:0]};
              left_nxt  = 2'd1;
              len_nxt   = 2'd1;
            end
            CLS_LEAD3: begin
              accum_nxt = {{(CP_W-4){1'b0}}, tok.data[3:0]};
              left_nxt  = 2'd2;
              len_nxt   = 2'd2;
            end
            CLS_LEAD4: begin
              accum_nxt = {{(CP_W-3){1'b0}}, tok.data[2:0]};
              left_nxt  = 2'd3;
              len_nxt   = 2'd3;
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end else if (tok.cls != CLS_CONT) begin
          err_nxt = 1'b1;
        end else begin
          left_nxt = left_r - 2'd1;
          if (left_r == 2'd1) begin
            err_nxt   = (cp_next < min_cp) || !range_ok(check_mode, cp_next);
            accum_nxt = '0;
            len_nxt   = 2'd0;
          end else begin
            accum_nxt = cp_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r <= out_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      left_r      <= 2'd0;
      len_r       <= 2'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      left_r      <= left_nxt;
      len_r       <= len_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/utf8_string_validator.sv
// Channel   Dir   Payload             Transaction
// in_ch     in    byte_in[7:0]        one string byte, zero ends the string
// out_ch    out   string_ok           one verdict per string
// cfg       in    cfg_wdata           check_mode, written when cfg_we is high
//
// One byte is taken per cycle while the queue is not full; a verdict is registered when its zero byte leaves the queue.
// Bytes pass through a two-entry queue between the classifier and the decoder.
// Reset is synchronous and clears the queue, the decoder state and check_mode.
// A stalled verdict stalls only zero bytes; other bytes keep draining the queue.
module utf8_string_validator
  import utf8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  utf8v_in_if.sink    in_ch,
  utf8v_out_if.source out_ch
);

  logic           check_mode_r;
  logic           push;
  logic           pop;
  utf8v_tok_t     push_tok;
  utf8v_tok_t     head_tok;
  utf8v_fifo_st_t fifo_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= MODE_UNICODE;
    end else if (cfg_we) begin
      check_mode_r <= cfg_wdata;
    end
  end

  utf8v_front u_front (
    .in_ch     (in_ch),
    .fifo_full (fifo_st.full),
    .push      (push),
    .push_tok  (push_tok)
  );

  utf8v_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .st       (fifo_st)
  );

  utf8v_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .check_mode (check_mode_r),
    .tok_valid  (!fifo_st.empty),
    .tok        (head_tok),
    .pop        (pop),
    .out_ch     (out_ch)
  );

`include "utf8_string_validator_macros.svh"

  `UTF8V_ASSERT_IMP(a_fifo_state, clk, rst_n, fifo_st.full, !fifo_st.empty)
  `UTF8V_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !fifo_st.empty)
  `UTF8V_ASSERT_NXT(a_zero_gives_verdict, clk, rst_n, pop && (head_tok.cls == CLS_ZERO), out_ch.valid)

endmodule
